/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// same, on the block's clk_i and rst_ni
`define ASSERT_DEF(lbl, prop) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

/* rtl/core/spq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // operation broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } op_t;

  // control handed from one cell to the next
  typedef struct packed {
    logic occ;    // cell holds an entry
    logic shift;  // cell's entry moves one place toward the tail on insert
  } link_t;

endpackage

`default_nettype wire

/* rtl/core/spq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
  parameter int IDX         = 0,
  parameter int CNT_W       = 9,
  parameter int KEY_BITS    = 32,
  parameter int HANDLE_BITS = 9
) (
  input  wire                     clk_i,
  input  spq_pkg::op_t            op_i,
  input  wire [CNT_W-1:0]         count_i,
  input  wire [KEY_BITS-1:0]      new_key_i,
  input  wire [HANDLE_BITS-1:0]   new_handle_i,
  input  spq_pkg::link_t          left_i,
  input  wire [KEY_BITS-1:0]      left_key_i,
  input  wire [HANDLE_BITS-1:0]   left_handle_i,
  input  wire [KEY_BITS-1:0]      right_key_i,
  input  wire [HANDLE_BITS-1:0]   right_handle_i,
  output spq_pkg::link_t          link_o,
  output logic [KEY_BITS-1:0]     key_o,
  output logic [HANDLE_BITS-1:0]  handle_o
);
  import spq_pkg::*;

  logic [KEY_BITS-1:0]    key_q, key_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  logic                   occ;
  logic                   shift;
  logic                   place;

  assign occ   = count_i > CNT_W'(IDX);
  assign shift = occ && (new_key_i >= key_q);
  // new entry lands at the first shifting cell, or right after the tail
  assign place = !left_i.shift && (shift || (!occ && left_i.occ));

  always_comb begin
    key_d    = key_q;
    handle_d = handle_q;
    if (op_i.ins) begin
      if (left_i.shift) begin
        key_d    = left_key_i;
        handle_d = left_handle_i;
      end else if (place) begin
        key_d    = new_key_i;
        handle_d = new_handle_i;
      end
    end else if (op_i.rem) begin
      key_d    = right_key_i;
      handle_d = right_handle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  assign link_o.occ   = occ;
  assign link_o.shift = shift;
  assign key_o        = key_q;
  assign handle_o     = handle_q;

endmodule

`default_nettype wire

/* rtl/core/sorted_priority_queue.sv */
// channel  direction  handshake                  payload
// in       sink       in_valid_i / in_ready_o    cmd_i, key_i, handle_i
// out      source     out_valid_o / out_ready_i  status_o, out_key_o, out_handle_o, count_o
//
// one transfer per cycle in each direction while no result is stalled; a result shows in the cycle after its input
// the whole row of cells compares and shifts in the same cycle as the input transfer
// reset empties the queue at once through the fill count; no clearing pass
// a stalled result holds in the output register; in_ready_o drops only while it waits
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH       = 256,
  parameter int KEY_BITS    = 32,
  parameter int HANDLE_BITS = 9,
  localparam int CNT_W      = $clog2(DEPTH + 1)
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire                     cmd_i,
  input  wire [KEY_BITS-1:0]      key_i,
  input  wire [HANDLE_BITS-1:0]   handle_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output logic [1:0]              status_o,
  output logic [KEY_BITS-1:0]     out_key_o,
  output logic [HANDLE_BITS-1:0]  out_handle_o,
  output logic [CNT_W-1:0]        count_o
);
  import spq_pkg::*;

  // fill level of the cell row
  logic [CNT_W-1:0] fill_q, fill_d;

  // result register
  logic                   out_valid_q, out_valid_d;
  status_e                status_q, status_d;
  logic [KEY_BITS-1:0]    out_key_q, out_key_d;
  logic [HANDLE_BITS-1:0] out_handle_q, out_handle_d;
  logic [CNT_W-1:0]       count_q;

  logic in_xfer;
  logic is_full;
  logic is_empty;
  op_t  op;

  // per-cell taps, read by the neighboring cells; the head's tap also feeds the result
  logic [KEY_BITS-1:0]    cell_key    [DEPTH];
  logic [HANDLE_BITS-1:0] cell_handle [DEPTH];
  link_t                  cell_link   [DEPTH];

  // a new transfer is taken whenever the result slot is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_full    = fill_q == CNT_W'(DEPTH);
  assign is_empty   = fill_q == '0;

  assign op.ins = in_xfer && (cmd_i == CMD_INSERT) && !is_full;
  assign op.rem = in_xfer && (cmd_i == CMD_REMOVE) && !is_empty;

  // the row of cells, head at index zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    link_t                  left;
    logic [KEY_BITS-1:0]    left_key, right_key;
    logic [HANDLE_BITS-1:0] left_handle, right_handle;

    if (i == 0) begin : g_head
      // the head sees a full, non-shifting neighbor ahead of it
      assign left.occ    = 1'b1;
      assign left.shift  = 1'b0;
      assign left_key    = key_i;
      assign left_handle = handle_i;
    end else begin : g_mid
      assign left        = cell_link[i-1];
      assign left_key    = cell_key[i-1];
      assign left_handle = cell_handle[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // the tail takes nothing from behind; its content is stale after a remove
      assign right_key    = cell_key[i];
      assign right_handle = cell_handle[i];
    end else begin : g_body
      assign right_key    = cell_key[i+1];
      assign right_handle = cell_handle[i+1];
    end

    spq_cell #(
      .IDX         (i),
      .CNT_W       (CNT_W),
      .KEY_BITS    (KEY_BITS),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .op_i           (op),
      .count_i        (fill_q),
      .new_key_i      (key_i),
      .new_handle_i   (handle_i),
      .left_i         (left),
      .left_key_i     (left_key),
      .left_handle_i  (left_handle),
      .right_key_i    (right_key),
      .right_handle_i (right_handle),
      .link_o         (cell_link[i]),
      .key_o          (cell_key[i]),
      .handle_o       (cell_handle[i])
    );
  end

  // next fill level and result
  always_comb begin
    fill_d       = fill_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    out_key_d    = out_key_q;
    out_handle_d = out_handle_q;
    if (in_xfer) begin
      out_valid_d  = 1'b1;
      out_key_d    = '0;
      out_handle_d = '0;
      if (cmd_i == CMD_INSERT) begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_INSERTED;
          fill_d   = fill_q + CNT_W'(1);
        end
      end else begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          status_d     = ST_REMOVED;
          out_key_d    = cell_key[0];
          out_handle_d = cell_handle[0];
          fill_d       = fill_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only on an input transfer
  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    out_key_q    <= out_key_d;
    out_handle_q <= out_handle_d;
    if (in_xfer) begin
      count_q <= fill_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign out_key_o    = out_key_q;
  assign out_handle_o = out_handle_q;
  assign count_o      = count_q;

endmodule

`default_nettype wire

/* rtl/core/spq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spq_checker #(
  parameter int DEPTH       = 256,
  parameter int KEY_BITS    = 32,
  parameter int HANDLE_BITS = 9,
  parameter int CNT_W       = $clog2(DEPTH + 1)
) (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    in_valid_i,
  input wire                    in_ready_o,
  input wire                    out_valid_o,
  input wire                    out_ready_i,
  input wire [1:0]              status_o,
  input wire [KEY_BITS-1:0]     out_key_o,
  input wire [HANDLE_BITS-1:0]  out_handle_o,
  input wire [CNT_W-1:0]        count_o
);
  import spq_pkg::*;

  // a waiting result stays until taken
  `ASSERT_DEF(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)

  // a transfer in always yields a result on the next cycle
  `ASSERT_DEF(a_result_follows, in_valid_i && in_ready_o |=> out_valid_o)

  // only a removal returns an entry
  `ASSERT_DEF(a_zero_payload,
    out_valid_o && (status_o != ST_REMOVED) |-> (out_key_o == '0) && (out_handle_o == '0))

  // empty and full reports agree with the count
  `ASSERT_DEF(a_empty_count, out_valid_o && (status_o == ST_EMPTY) |-> count_o == '0)
  `ASSERT_DEF(a_full_count,
    out_valid_o && (status_o == ST_FULL) |-> count_o == CNT_W'(DEPTH))

endmodule

bind sorted_priority_queue spq_checker #(
  .DEPTH       (DEPTH),
  .KEY_BITS    (KEY_BITS),
  .HANDLE_BITS (HANDLE_BITS),
  .CNT_W       (CNT_W)
) u_spq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .out_key_o    (out_key_o),
  .out_handle_o (out_handle_o),
  .count_o      (count_o)
);

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import spq_pkg::*;

  localparam int DEPTH       = 256;
  localparam int KEY_BITS    = 32;
  localparam int HANDLE_BITS = 9;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;

  // one result as the block should report it
  typedef struct packed {
    status_e                st;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] hnd;
    logic [CNT_W-1:0]       cnt;
  } result_t;

  // one row of the directed table; fixed marks rows whose result is typed in
  typedef struct packed {
    logic                   cmd;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] hnd;
    logic                   fixed;
    result_t                res;
  } row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   cmd_i;
  logic [KEY_BITS-1:0]    key_i;
  logic [HANDLE_BITS-1:0] handle_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [1:0]             status_o;
  logic [KEY_BITS-1:0]    out_key_o;
  logic [HANDLE_BITS-1:0] out_handle_o;
  logic [CNT_W-1:0]       count_o;

  sorted_priority_queue #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .HANDLE_BITS(HANDLE_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .handle_i    (handle_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .out_key_o   (out_key_o),
    .out_handle_o(out_handle_o),
    .count_o     (count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow copy of the sorted store, head at slot 0
  logic [KEY_BITS-1:0]    key_mem [DEPTH];
  logic [HANDLE_BITS-1:0] hnd_mem [DEPTH];
  int                     fill_cnt;
  int                     peak_fill;

  result_t                pending_results[$];
  result_t                want;
  row_t                   plan[$];

  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int cycle_cnt;
  int sent_cnt;
  int n_insert, n_remove, n_empty, n_full;

  // apply one operation to the shadow store and return the result it gives
  function automatic result_t apply_queue_op(input logic cmd, input logic [KEY_BITS-1:0] key,
                                             input logic [HANDLE_BITS-1:0] hnd);
    result_t r;
    int      pos;
    r = '{ST_INSERTED, '0, '0, '0};
    if (cmd == CMD_INSERT) begin
      if (fill_cnt >= DEPTH) begin
        r.st = ST_FULL;
      end else begin
        // new entry goes ahead of the first entry whose key is not larger
        pos = 0;
        while (pos < fill_cnt && key < key_mem[pos]) pos++;
        for (int i = fill_cnt; i > pos; i--) begin
          key_mem[i] = key_mem[i-1];
          hnd_mem[i] = hnd_mem[i-1];
        end
        key_mem[pos] = key;
        hnd_mem[pos] = hnd;
        fill_cnt++;
        r.st = ST_INSERTED;
      end
    end else begin
      if (fill_cnt == 0) begin
        r.st = ST_EMPTY;
      end else begin
        r.key = key_mem[0];
        r.hnd = hnd_mem[0];
        for (int i = 1; i < fill_cnt; i++) begin
          key_mem[i-1] = key_mem[i];
          hnd_mem[i-1] = hnd_mem[i];
        end
        fill_cnt--;
        r.st = ST_REMOVED;
      end
    end
    r.cnt = CNT_W'(fill_cnt);
    return r;
  endfunction

  // present one operation at a falling edge and hold it until the transfer
  task automatic send_op(input logic cmd, input logic [KEY_BITS-1:0] key,
                         input logic [HANDLE_BITS-1:0] hnd, input logic fixed,
                         input result_t fixed_res);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    key_i      <= key;
    handle_i   <= hnd;
    do @(posedge clk_i); while (!in_ready_o);
    r = apply_queue_op(cmd, key, hnd);
    case (r.st)
      ST_INSERTED: n_insert++;
      ST_REMOVED:  n_remove++;
      ST_EMPTY:    n_empty++;
      default:     n_full++;
    endcase
    if (fill_cnt > peak_fill) peak_fill = fill_cnt;
    pending_results.push_back(fixed ? fixed_res : r);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // random operation; keys lean toward a narrow range so ties are common
  task automatic random_op(input int ins_pct);
    logic                cmd;
    logic [KEY_BITS-1:0] key;
    int                  pick;
    cmd  = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
    pick = $urandom_range(9);
    if (pick < 4) begin
      key = KEY_BITS'($urandom_range(7));
    end else if (pick == 4) begin
      case ($urandom_range(3))
        0:       key = '0;
        1:       key = '1;
        2:       key = {1'b1, {(KEY_BITS-1){1'b0}}};
        default: key = {1'b0, {(KEY_BITS-1){1'b1}}};
      endcase
    end else begin
      key = $urandom;
    end
    send_op(cmd, key, HANDLE_BITS'($urandom_range(2**HANDLE_BITS - 1)), 1'b0, '0);
  endtask

  // runs of random length, each with its own lean toward inserts or removes
  task automatic random_runs(input int stop_at);
    int run_len;
    int ins_pct;
    while (sent_cnt < stop_at) begin
      run_len = $urandom_range(20, 120);
      case ($urandom_range(4))
        0:       ins_pct = 10;
        1:       ins_pct = 35;
        2:       ins_pct = 50;
        3:       ins_pct = 65;
        default: ins_pct = 90;
      endcase
      repeat (run_len) random_op(ins_pct);
    end
  endtask

  // receiver: ready changes on the falling edge
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result check, one transfer at a time against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d key %h handle %h count %0d",
                 $time, status_o, out_key_o, out_handle_o, count_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.st, status_o);
        end
        if (out_key_o !== want.key) begin
          errors++;
          $display("%0t: out_key expected %h actual %h", $time, want.key, out_key_o);
        end
        if (out_handle_o !== want.hnd) begin
          errors++;
          $display("%0t: out_handle expected %h actual %h", $time, want.hnd, out_handle_o);
        end
        if (count_o !== want.cnt) begin
          errors++;
          $display("%0t: count expected %0d actual %0d", $time, want.cnt, count_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("[sorted_priority_queue] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_INSERT;
    key_i         = '0;
    handle_i      = '0;
    out_ready_i   = 1'b0;
    fill_cnt      = 0;
    peak_fill     = 0;
    errors        = 0;
    cycle_cnt     = 0;
    sent_cnt      = 0;
    n_insert      = 0;
    n_remove      = 0;
    n_empty       = 0;
    n_full        = 0;
    send_idle_pct = 30;
    recv_idle_pct = 57;

    // directed rows: extremes, tie order, remove on empty
    plan.push_back('{CMD_REMOVE, '0, '0, 1'b1, '{ST_EMPTY, '0, '0, 9'd0}});
    plan.push_back('{CMD_INSERT, '0, '0, 1'b1, '{ST_INSERTED, '0, '0, 9'd1}});
    plan.push_back('{CMD_INSERT, '1, '1, 1'b1, '{ST_INSERTED, '0, '0, 9'd2}});
    plan.push_back('{CMD_INSERT, 32'd5, 9'd1, 1'b0, '0});
    plan.push_back('{CMD_INSERT, 32'd5, 9'd2, 1'b0, '0});
    plan.push_back('{CMD_INSERT, 32'd5, 9'd3, 1'b0, '0});
    plan.push_back('{CMD_INSERT, 32'd1, 9'd4, 1'b0, '0});
    plan.push_back('{CMD_REMOVE, '0, '0, 1'b1, '{ST_REMOVED, '1, '1, 9'd5}});
    plan.push_back('{CMD_REMOVE, '1, '1, 1'b0, '0});
    plan.push_back('{CMD_REMOVE, '0, '0, 1'b0, '0});
    plan.push_back('{CMD_REMOVE, '0, '0, 1'b0, '0});
    plan.push_back('{CMD_REMOVE, '0, '0, 1'b0, '0});
    plan.push_back('{CMD_REMOVE, '0, '0, 1'b0, '0});
    plan.push_back('{CMD_REMOVE, '0, '0, 1'b1, '{ST_EMPTY, '0, '0, 9'd0}});
    plan.push_back('{CMD_INSERT, 32'h8000_0000, 9'h100, 1'b0, '0});
    plan.push_back('{CMD_INSERT, 32'h7fff_ffff, 9'h0ff, 1'b0, '0});
    plan.push_back('{CMD_INSERT, 32'h5555_5555, 9'h155, 1'b0, '0});
    plan.push_back('{CMD_INSERT, 32'haaaa_aaaa, 9'h0aa, 1'b0, '0});
    plan.push_back('{CMD_REMOVE, '0, '0, 1'b0, '0});
    plan.push_back('{CMD_REMOVE, '0, '0, 1'b0, '0});
    plan.push_back('{CMD_REMOVE, '0, '0, 1'b0, '0});
    plan.push_back('{CMD_REMOVE, '0, '0, 1'b0, '0});

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) send_op(plan[i].cmd, plan[i].key, plan[i].hnd, plan[i].fixed, plan[i].res);

    // fill to the brim, push past it, then drain past empty
    while (fill_cnt < DEPTH) random_op(95);
    repeat (4) random_op(100);
    while (fill_cnt > 0) random_op(5);
    repeat (3) random_op(0);
    random_runs(600);

    send_idle_pct = 57;
    recv_idle_pct = 30;
    random_runs(1075);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_runs(1550);
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("ran %0d operations in %0d cycles, store filled up to %0d entries",
             sent_cnt, cycle_cnt, peak_fill);
    $display("inserts %0d, removes %0d, removes on empty %0d, inserts dropped full %0d",
             n_insert, n_remove, n_empty, n_full);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[sorted_priority_queue] OK");
    end else begin
      $display("[sorted_priority_queue] ERROR");
    end
    $finish;
  end

endmodule
